// ===== rtl/cadp_pkg.sv =====
// ----------------------------------------------------------------------------
// cadp_pkg
// Shared constants, types and helper functions of the attractor density plot.
// ----------------------------------------------------------------------------
package cadp_pkg;

    // Pixel grid
    localparam int GRID_W = 1024;
    localparam int GRID_H = 768;
    localparam int NPIX   = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(NPIX);

    // Histogram word: three saturating channel sums
    localparam int SUM_W  = 32;
    localparam int HIST_W = 3 * SUM_W;

    // Radians (Q5.30) to turns scale factor, used as bits [53:38] of P*K
    localparam logic [21:0] PHASE_K = 22'd2670177;

    // Quarter-wave sine polynomial coefficients, Q24
    localparam logic [24:0] PC1 = 25'd26353589;
    localparam logic [24:0] PC3 = 25'd10837479;
    localparam logic [24:0] PC5 = 25'd1337020;
    localparam logic [24:0] PC7 = 25'd78547;
    localparam logic [24:0] PC9 = 25'd2692;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    localparam logic signed [18:0] Q316_MAX = 19'sh3FFFF;
    localparam logic signed [18:0] Q316_MIN = 19'sh40000;

    typedef logic signed [18:0] t_q316;
    typedef logic signed [15:0] t_q14;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_COEF_A = 3'd0,
        CFG_COEF_B = 3'd1,
        CFG_COEF_C = 3'd2,
        CFG_COEF_D = 3'd3,
        CFG_HUE    = 3'd4,
        CFG_SKIP   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_q14 a;
        t_q14 b;
        t_q14 c;
        t_q14 d;
    } t_coefs;

    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } t_rgbw;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ORBIT,
        ST_RMW,
        ST_READ,
        ST_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        OB_IDLE,
        OB_MUL,
        OB_PHASE,
        OB_TRIG,
        OB_WAIT,
        OB_MAP,
        OB_SUM,
        OB_DONE
    } t_orb_state;

    typedef enum logic [2:0] {
        SN_IDLE,
        SN_SQR,
        SN_POLY,
        SN_FIN,
        SN_DONE
    } t_sin_state;

    // Hue to RGB weights, 1.0 = 256
    function automatic t_rgbw hue_weights(logic [15:0] hue);
        logic [18:0] h6;
        logic [8:0]  f;
        logic [8:0]  inv;
        t_rgbw       w;
        h6  = {3'b000, hue} * 19'd6;
        f   = {1'b0, h6[15:8]};
        inv = 9'd256 - f;
        case (h6[18:16])
            3'd0:    w = '{r: 9'd256, g: f,       b: 9'd0};
            3'd1:    w = '{r: inv,    g: 9'd256,  b: 9'd0};
            3'd2:    w = '{r: 9'd0,   g: 9'd256,  b: f};
            3'd3:    w = '{r: 9'd0,   g: inv,     b: 9'd256};
            3'd4:    w = '{r: f,      g: 9'd0,    b: 9'd256};
            default: w = '{r: 9'd256, g: 9'd0,    b: inv};
        endcase
        return w;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [8:0] w);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(w);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic t_q316 sat_q316(logic signed [20:0] v);
        t_q316 r;
        if (v > 21'(Q316_MAX)) begin
            r = Q316_MAX;
        end else if (v < 21'(Q316_MIN)) begin
            r = Q316_MIN;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/cadp_ram.sv =====
// ----------------------------------------------------------------------------
// cadp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cadp_ram #(
    parameter int DATA_W = 96,
    parameter int DEPTH  = 786432,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cadp_sin.sv =====
// ----------------------------------------------------------------------------
// cadp_sin
// Iterative Q1.14 sine of a 16-bit phase, one shared multiplier per cycle.
// ----------------------------------------------------------------------------
module cadp_sin (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_phase,
    output logic               o_done,
    output cadp_pkg::t_q14     o_value
);

    cadp_pkg::t_sin_state r_state, n_state;
    logic                 r_neg, n_neg;
    logic [24:0]          r_z, n_z;
    logic [24:0]          r_z2, n_z2;
    logic [24:0]          r_t, n_t;
    logic [1:0]           r_cnt, n_cnt;
    cadp_pkg::t_q14       r_value, n_value;

    logic [14:0] w_u;
    logic [24:0] w_ma, w_mb, w_pc;
    logic [49:0] w_m;
    logic [25:0] w_sub;
    logic [26:0] w_rnd;
    logic [16:0] w_sr;
    logic [14:0] w_s;

    // Shared multiplier
    assign w_ma = (r_state == cadp_pkg::SN_POLY) ? r_z2 : r_z;
    assign w_mb = (r_state == cadp_pkg::SN_SQR)  ? r_z  : r_t;
    assign w_m  = 50'(w_ma) * 50'(w_mb);

    // Horner coefficient for the current step
    always_comb begin
        case (r_cnt)
            2'd0:    w_pc = cadp_pkg::PC7;
            2'd1:    w_pc = cadp_pkg::PC5;
            2'd2:    w_pc = cadp_pkg::PC3;
            default: w_pc = cadp_pkg::PC1;
        endcase
    end

    // Quadrant fold
    assign w_u   = i_phase[14] ? (15'd16384 - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
    assign w_sub = {1'b0, w_pc} - w_m[49:24];
    assign w_rnd = {1'b0, w_m[49:24]} + 27'd512;
    assign w_sr  = w_rnd[26:10];
    assign w_s   = (w_sr > 17'd16384) ? 15'd16384 : w_sr[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cadp_pkg::SN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_z     <= n_z;
        r_z2    <= n_z2;
        r_t     <= n_t;
        r_cnt   <= n_cnt;
        r_value <= n_value;
    end

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_z     = r_z;
        n_z2    = r_z2;
        n_t     = r_t;
        n_cnt   = r_cnt;
        n_value = r_value;
        o_done  = 1'b0;
        unique case (r_state)
            cadp_pkg::SN_IDLE: begin
                if (i_start) begin
                    n_neg   = i_phase[15];
                    n_z     = {w_u, 10'b0};
                    n_state = cadp_pkg::SN_SQR;
                end
            end
            cadp_pkg::SN_SQR: begin
                n_z2    = w_m[48:24];
                n_t     = cadp_pkg::PC9;
                n_cnt   = 2'd0;
                n_state = cadp_pkg::SN_POLY;
            end
            cadp_pkg::SN_POLY: begin
                n_t   = w_sub[24:0];
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = cadp_pkg::SN_FIN;
                end
            end
            cadp_pkg::SN_FIN: begin
                n_value = r_neg ? -$signed({1'b0, w_s}) : $signed({1'b0, w_s});
                n_state = cadp_pkg::SN_DONE;
            end
            cadp_pkg::SN_DONE: begin
                o_done  = 1'b1;
                n_state = cadp_pkg::SN_IDLE;
            end
            default: begin
                n_state = cadp_pkg::SN_IDLE;
            end
        endcase
    end

    assign o_value = r_value;

endmodule

// ===== rtl/cadp_orbit.sv =====
// ----------------------------------------------------------------------------
// cadp_orbit
// One Clifford map iteration: four angles through a shared sine unit.
// ----------------------------------------------------------------------------
module cadp_orbit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cadp_pkg::t_coefs    i_coefs,
    input  cadp_pkg::t_q316     i_pos_x,
    input  cadp_pkg::t_q316     i_pos_y,
    output logic                o_done,
    output cadp_pkg::t_q316     o_nx,
    output cadp_pkg::t_q316     o_ny
);

    cadp_pkg::t_orb_state r_state, n_state;
    logic [1:0]           r_ang, n_ang;
    logic signed [34:0]   r_p, n_p;
    logic [15:0]          r_phase, n_phase;
    cadp_pkg::t_q14       r_s_ay, n_s_ay, r_c_ax, n_c_ax;
    cadp_pkg::t_q14       r_s_bx, n_s_bx, r_c_by, n_c_by;
    logic signed [31:0]   r_pc, n_pc, r_pd, n_pd;
    cadp_pkg::t_q316      r_nx, n_nx, r_ny, n_ny;

    cadp_pkg::t_q14       w_coef;
    cadp_pkg::t_q316      w_pos;
    logic signed [56:0]   w_pk;
    logic signed [20:0]   w_vx, w_vy;
    logic                 w_sin_start;
    logic                 w_sin_done;
    cadp_pkg::t_q14       w_sin_val;

    // Angle order: a*y (sin), a*x (cos), b*x (sin), b*y (cos)
    assign w_coef = r_ang[1] ? i_coefs.b : i_coefs.a;
    assign w_pos  = (r_ang[0] ^ r_ang[1]) ? i_pos_x : i_pos_y;
    assign w_pk   = 57'(r_p) * 57'($signed({1'b0, cadp_pkg::PHASE_K}));

    // Map sums: sin << 2 plus floor(coef * cos / 4096)
    assign w_vx = (21'(r_s_ay) <<< 2) + 21'(r_pc >>> 12);
    assign w_vy = (21'(r_s_bx) <<< 2) + 21'(r_pd >>> 12);

    cadp_sin u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sin_start),
        .i_phase (r_phase),
        .o_done  (w_sin_done),
        .o_value (w_sin_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cadp_pkg::OB_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang   <= n_ang;
        r_p     <= n_p;
        r_phase <= n_phase;
        r_s_ay  <= n_s_ay;
        r_c_ax  <= n_c_ax;
        r_s_bx  <= n_s_bx;
        r_c_by  <= n_c_by;
        r_pc    <= n_pc;
        r_pd    <= n_pd;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
    end

    always_comb begin
        n_state     = r_state;
        n_ang       = r_ang;
        n_p         = r_p;
        n_phase     = r_phase;
        n_s_ay      = r_s_ay;
        n_c_ax      = r_c_ax;
        n_s_bx      = r_s_bx;
        n_c_by      = r_c_by;
        n_pc        = r_pc;
        n_pd        = r_pd;
        n_nx        = r_nx;
        n_ny        = r_ny;
        w_sin_start = 1'b0;
        o_done      = 1'b0;
        unique case (r_state)
            cadp_pkg::OB_IDLE: begin
                if (i_start) begin
                    n_ang   = 2'd0;
                    n_state = cadp_pkg::OB_MUL;
                end
            end
            cadp_pkg::OB_MUL: begin
                n_p     = 35'(w_coef) * 35'(w_pos);
                n_state = cadp_pkg::OB_PHASE;
            end
            cadp_pkg::OB_PHASE: begin
                // cosine is the sine a quarter turn ahead
                n_phase = w_pk[53:38] + (r_ang[0] ? cadp_pkg::QUARTER_TURN : 16'd0);
                n_state = cadp_pkg::OB_TRIG;
            end
            cadp_pkg::OB_TRIG: begin
                w_sin_start = 1'b1;
                n_state     = cadp_pkg::OB_WAIT;
            end
            cadp_pkg::OB_WAIT: begin
                if (w_sin_done) begin
                    case (r_ang)
                        2'd0:    n_s_ay = w_sin_val;
                        2'd1:    n_c_ax = w_sin_val;
                        2'd2:    n_s_bx = w_sin_val;
                        default: n_c_by = w_sin_val;
                    endcase
                    n_ang   = r_ang + 2'd1;
                    n_state = (r_ang == 2'd3) ? cadp_pkg::OB_MAP : cadp_pkg::OB_MUL;
                end
            end
            cadp_pkg::OB_MAP: begin
                n_pc    = 32'(i_coefs.c) * 32'(r_c_ax);
                n_pd    = 32'(i_coefs.d) * 32'(r_c_by);
                n_state = cadp_pkg::OB_SUM;
            end
            cadp_pkg::OB_SUM: begin
                n_nx    = cadp_pkg::sat_q316(w_vx);
                n_ny    = cadp_pkg::sat_q316(w_vy);
                n_state = cadp_pkg::OB_DONE;
            end
            cadp_pkg::OB_DONE: begin
                o_done  = 1'b1;
                n_state = cadp_pkg::OB_IDLE;
            end
            default: begin
                n_state = cadp_pkg::OB_IDLE;
            end
        endcase
    end

    assign o_nx = r_nx;
    assign o_ny = r_ny;

endmodule

// ===== rtl/clifford_attractor_density_plot_core.sv =====
// ----------------------------------------------------------------------------
// clifford_attractor_density_plot_core: Clifford attractor density plotter
// Step: four angle passes through the iterative sine unit, then, when a pixel is
// updated, a read-modify-write of the histogram. Restart, no-op and out-of-range
// read go straight to the result; an in-range read first reads the RAM. One transaction
// at a time: the next is accepted the cycle after the result is loaded.
// Reset clears the histogram RAM one pixel per cycle, all GRID_W*GRID_H pixels.
// ----------------------------------------------------------------------------
module clifford_attractor_density_plot_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [23:0]   i_s_tdata,   // [19:0] pixel_index
    input  logic [1:0]    i_s_tuser,   // [1:0] opcode
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [135:0]  o_m_tdata,   // red_sum, green_sum, blue_sum, orbit_x, orbit_y
    output logic [0:0]    o_m_tuser,   // [0] plotted
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata
);

    localparam int AW = cadp_pkg::ADDR_W;
    localparam int SW = cadp_pkg::SUM_W;

    // Configuration registers
    cadp_pkg::t_coefs     r_coefs;
    logic [15:0]          r_hue;
    logic [7:0]           r_skip;

    cadp_pkg::t_top_state r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [AW-1:0]        r_addr, n_addr;
    cadp_pkg::t_q316      r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [7:0]           r_skipped, n_skipped;
    logic [SW-1:0]        r_res_r, n_res_r, r_res_g, n_res_g, r_res_b, n_res_b;
    logic                 r_res_plot, n_res_plot;

    logic                 r_m_valid;
    logic [135:0]         r_m_data;
    logic                 r_m_plot;
    logic                 w_load;

    logic                 w_accept;
    cadp_pkg::t_opcode    w_op;
    logic                 w_orb_start;
    logic                 w_orb_done;
    cadp_pkg::t_q316      w_nx, w_ny;

    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [cadp_pkg::HIST_W-1:0] w_wdata, w_rdata;

    logic signed [39:0]   w_colx, w_rowx, w_col, w_row;
    logic                 w_inside;
    logic [AW-1:0]        w_idx;
    cadp_pkg::t_rgbw      w_wt;
    logic [SW-1:0]        w_sum_r, w_sum_g, w_sum_b;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
            r_hue   <= '0;
            r_skip  <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (cadp_pkg::t_cfg_idx'(i_cfg_addr))
                cadp_pkg::CFG_COEF_A: r_coefs.a <= i_cfg_wdata;
                cadp_pkg::CFG_COEF_B: r_coefs.b <= i_cfg_wdata;
                cadp_pkg::CFG_COEF_C: r_coefs.c <= i_cfg_wdata;
                cadp_pkg::CFG_COEF_D: r_coefs.d <= i_cfg_wdata;
                cadp_pkg::CFG_HUE:    r_hue     <= i_cfg_wdata;
                cadp_pkg::CFG_SKIP:   r_skip    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    cadp_orbit u_orbit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_orb_start),
        .i_coefs (r_coefs),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .o_done  (w_orb_done),
        .o_nx    (w_nx),
        .o_ny    (w_ny)
    );

    cadp_ram #(
        .DATA_W (cadp_pkg::HIST_W),
        .DEPTH  (cadp_pkg::NPIX),
        .ADDR_W (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Point to pixel, floor division by 2^19
    assign w_colx   = 40'(w_nx) * 40'(cadp_pkg::GRID_W) + 40'(cadp_pkg::GRID_W * 262144);
    assign w_rowx   = 40'(w_ny) * 40'(cadp_pkg::GRID_W) + 40'(cadp_pkg::GRID_H * 262144);
    assign w_col    = w_colx >>> 19;
    assign w_row    = w_rowx >>> 19;
    assign w_inside = (w_col >= 0) && (w_col < 40'(cadp_pkg::GRID_W)) &&
                      (w_row >= 0) && (w_row < 40'(cadp_pkg::GRID_H));
    assign w_idx    = AW'(w_col) + AW'(w_row * 40'(cadp_pkg::GRID_W));

    // Weighted saturating update
    assign w_wt    = cadp_pkg::hue_weights(r_hue);
    assign w_sum_r = cadp_pkg::sat_add(w_rdata[SW-1:0],      w_wt.r);
    assign w_sum_g = cadp_pkg::sat_add(w_rdata[2*SW-1:SW],   w_wt.g);
    assign w_sum_b = cadp_pkg::sat_add(w_rdata[3*SW-1:2*SW], w_wt.b);

    assign w_op     = cadp_pkg::t_opcode'(i_s_tuser);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_load   = (r_state == cadp_pkg::ST_DONE) && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cadp_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_skipped  <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_skipped  <= n_skipped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_res_r    <= n_res_r;
        r_res_g    <= n_res_g;
        r_res_b    <= n_res_b;
        r_res_plot <= n_res_plot;
    end

    // Sequencer: next state, RAM port control and result capture
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_addr      = r_addr;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_skipped   = r_skipped;
        n_res_r     = r_res_r;
        n_res_g     = r_res_g;
        n_res_b     = r_res_b;
        n_res_plot  = r_res_plot;
        o_s_tready  = 1'b0;
        w_orb_start = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = {w_sum_b, w_sum_g, w_sum_r};
        w_raddr     = r_addr;
        unique case (r_state)
            cadp_pkg::ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(cadp_pkg::NPIX - 1)) begin
                    n_state = cadp_pkg::ST_IDLE;
                end
            end
            cadp_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (w_accept) begin
                    n_res_r    = '0;
                    n_res_g    = '0;
                    n_res_b    = '0;
                    n_res_plot = 1'b0;
                    n_state    = cadp_pkg::ST_DONE;
                    unique case (w_op)
                        cadp_pkg::OP_RESTART: begin
                            n_pos_x   = '0;
                            n_pos_y   = '0;
                            n_skipped = '0;
                        end
                        cadp_pkg::OP_STEP: begin
                            w_orb_start = 1'b1;
                            n_state     = cadp_pkg::ST_ORBIT;
                        end
                        cadp_pkg::OP_READ: begin
                            if (32'(i_s_tdata[19:0]) < 32'(cadp_pkg::NPIX)) begin
                                w_raddr = AW'(i_s_tdata[19:0]);
                                n_state = cadp_pkg::ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cadp_pkg::ST_ORBIT: begin
                if (w_orb_done) begin
                    n_pos_x = w_nx;
                    n_pos_y = w_ny;
                    n_state = cadp_pkg::ST_DONE;
                    if (r_skipped < r_skip) begin
                        n_skipped = r_skipped + 8'd1;
                    end else if (w_inside) begin
                        w_raddr = w_idx;
                        n_addr  = w_idx;
                        n_state = cadp_pkg::ST_RMW;
                    end
                end
            end
            cadp_pkg::ST_RMW: begin
                // read data of r_addr is here; write the sums back
                w_we       = 1'b1;
                n_res_r    = w_sum_r;
                n_res_g    = w_sum_g;
                n_res_b    = w_sum_b;
                n_res_plot = 1'b1;
                n_state    = cadp_pkg::ST_DONE;
            end
            cadp_pkg::ST_READ: begin
                n_res_r = w_rdata[SW-1:0];
                n_res_g = w_rdata[2*SW-1:SW];
                n_res_b = w_rdata[3*SW-1:2*SW];
                n_state = cadp_pkg::ST_DONE;
            end
            cadp_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = cadp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cadp_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= {2'b00, r_pos_y, r_pos_x, r_res_b, r_res_g, r_res_r};
            r_m_plot <= r_res_plot;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_plot;

`ifndef ASSERT_OFF
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cadp_pkg::ST_CLEAR) |-> !o_s_tready)
        else $error("input accepted during histogram clear");

    a_plot_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[95:0] != '0))
        else $error("plotted result with zero sums");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == cadp_pkg::ST_CLEAR || r_state == cadp_pkg::ST_RMW))
        else $error("histogram write outside clear or update");

    a_orb_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_orb_done |-> (r_state == cadp_pkg::ST_ORBIT))
        else $error("orbit finished with no step pending");

    a_rmw_after_orbit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cadp_pkg::ST_RMW) |-> $past(r_state == cadp_pkg::ST_ORBIT))
        else $error("pixel update without an orbit step");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: Clifford attractor density plot core regression
// Drives restart, step, read and no-op transactions with random gaps and
// output stalls, predicts every result with an independent fixed-point model
// of the orbit, sine polynomial and pixel histogram, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [23:0]   i_s_tdata;
    logic [1:0]    i_s_tuser;
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [135:0]  o_m_tdata;
    logic [0:0]    o_m_tuser;
    logic          i_cfg_we;
    logic [2:0]    i_cfg_addr;
    logic [15:0]   i_cfg_wdata;

    clifford_attractor_density_plot_core uut (.*);

    // Clock, 10 ns period
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    typedef struct {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        plotted;
        logic [18:0] orbit_x;
        logic [18:0] orbit_y;
    } t_pixel_result;

    // Shadow of the block's configuration and state
    longint      mdl_a, mdl_b, mdl_c, mdl_d;
    logic [15:0] mdl_hue;
    logic [7:0]  mdl_skip;
    longint      mdl_x, mdl_y;
    logic [7:0]  mdl_skipped;
    logic [31:0] hist_red[int];
    logic [31:0] hist_green[int];
    logic [31:0] hist_blue[int];
    int          lit_pixels[$];

    t_pixel_result pending_results[$];
    int  fail_count = 0;
    bit  no_idle    = 0;
    bit  hold_req   = 0;
    int  idle_cycles = 0;

    localparam int WATCHDOG_LIMIT = 2_500_000;
    localparam int DRAIN_CYCLES   = 80;

    // ---------------- prediction ----------------
    function automatic logic [15:0] angle_phase(longint coef, longint pos);
        logic [63:0] p;
        p = 64'(coef * pos) * 64'd2670177;
        return p[53:38];
    endfunction

    function automatic longint quarter_wave(logic [15:0] u);
        logic [63:0] z, z2, t, s;
        z  = 64'(u) << 10;
        z2 = (z * z) >> 24;
        t  = 64'd2692;
        t  = 64'd78547    - ((z2 * t) >> 24);
        t  = 64'd1337020  - ((z2 * t) >> 24);
        t  = 64'd10837479 - ((z2 * t) >> 24);
        t  = 64'd26353589 - ((z2 * t) >> 24);
        s  = (((z * t) >> 24) + 64'd512) >> 10;
        if (s > 64'd16384) s = 64'd16384;
        return longint'(s);
    endfunction

    function automatic longint sine_q14(logic [15:0] ph);
        logic [1:0]  q;
        logic [15:0] r;
        longint      s;
        q = ph[15:14];
        r = {2'b00, ph[13:0]};
        s = quarter_wave(q[0] ? 16'd16384 - r : r);
        return q[1] ? -s : s;
    endfunction

    function automatic longint cosine_q14(logic [15:0] ph);
        return sine_q14(ph + 16'h4000);
    endfunction

    function automatic longint next_coord(longint sn, longint coef, longint cs);
        longint v;
        v = sn * 4 + ((coef * cs) >>> 12);
        if (v > 262143) v = 262143;
        if (v < -262144) v = -262144;
        return v;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [8:0] w);
        logic [32:0] s;
        s = {1'b0, a} + 33'(w);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Work out the result of one accepted transaction and update the shadow
    function automatic t_pixel_result predict_pixel(cadp_pkg::t_opcode op, logic [19:0] pix);
        t_pixel_result res;
        longint nx, ny, col, row;
        int     idx;
        logic [18:0] h6;
        logic [8:0]  f, wr, wg, wb;
        res = '{red: 0, green: 0, blue: 0, plotted: 0, orbit_x: 0, orbit_y: 0};
        case (op)
            cadp_pkg::OP_RESTART: begin
                mdl_x = 0; mdl_y = 0; mdl_skipped = 0;
            end
            cadp_pkg::OP_STEP: begin
                nx = next_coord(sine_q14(angle_phase(mdl_a, mdl_y)), mdl_c,
                                cosine_q14(angle_phase(mdl_a, mdl_x)));
                ny = next_coord(sine_q14(angle_phase(mdl_b, mdl_x)), mdl_d,
                                cosine_q14(angle_phase(mdl_b, mdl_y)));
                mdl_x = nx; mdl_y = ny;
                if (mdl_skipped < mdl_skip) begin
                    mdl_skipped = mdl_skipped + 8'd1;
                end else begin
                    col = (nx * 1024 + 1024 * 262144) >>> 19;
                    row = (ny * 1024 + 768 * 262144) >>> 19;
                    if (col >= 0 && col < 1024 && row >= 0 && row < 768) begin
                        idx = int'(col + row * 1024);
                        h6  = {3'b000, mdl_hue} * 19'd6;
                        f   = {1'b0, h6[15:8]};
                        case (h6[18:16])
                            3'd0:    begin wr = 256;     wg = f;       wb = 0;       end
                            3'd1:    begin wr = 256 - f; wg = 256;     wb = 0;       end
                            3'd2:    begin wr = 0;       wg = 256;     wb = f;       end
                            3'd3:    begin wr = 0;       wg = 256 - f; wb = 256;     end
                            3'd4:    begin wr = f;       wg = 0;       wb = 256;     end
                            default: begin wr = 256;     wg = 0;       wb = 256 - f; end
                        endcase
                        if (!hist_red.exists(idx)) begin
                            hist_red[idx] = 0; hist_green[idx] = 0; hist_blue[idx] = 0;
                            lit_pixels.push_back(idx);
                        end
                        hist_red[idx]   = add_sat(hist_red[idx], wr);
                        hist_green[idx] = add_sat(hist_green[idx], wg);
                        hist_blue[idx]  = add_sat(hist_blue[idx], wb);
                        res.red   = hist_red[idx];
                        res.green = hist_green[idx];
                        res.blue  = hist_blue[idx];
                        res.plotted = 1'b1;
                    end
                end
            end
            cadp_pkg::OP_READ: begin
                idx = int'(pix);
                if (hist_red.exists(idx)) begin
                    res.red = hist_red[idx]; res.green = hist_green[idx];
                    res.blue = hist_blue[idx];
                end
            end
            default: ;
        endcase
        res.orbit_x = mdl_x[18:0];
        res.orbit_y = mdl_y[18:0];
        return res;
    endfunction

    // ---------------- input side ----------------
    task automatic send_item(cadp_pkg::t_opcode op, logic [19:0] pix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'h0, pix};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_pixel(op, pix));
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; caller drops it
    task automatic write_reg(cadp_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            cadp_pkg::CFG_COEF_A: mdl_a = longint'(signed'(val));
            cadp_pkg::CFG_COEF_B: mdl_b = longint'(signed'(val));
            cadp_pkg::CFG_COEF_C: mdl_c = longint'(signed'(val));
            cadp_pkg::CFG_COEF_D: mdl_d = longint'(signed'(val));
            cadp_pkg::CFG_HUE:    mdl_hue = val;
            default:              mdl_skip = val[7:0];
        endcase
    endtask

    task automatic set_config(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [15:0] d, logic [15:0] hue, logic [7:0] skip);
        wait_idle();
        write_reg(cadp_pkg::CFG_COEF_A, a);
        write_reg(cadp_pkg::CFG_COEF_B, b);
        write_reg(cadp_pkg::CFG_COEF_C, c);
        write_reg(cadp_pkg::CFG_COEF_D, d);
        write_reg(cadp_pkg::CFG_HUE, hue);
        write_reg(cadp_pkg::CFG_SKIP, {8'h00, skip});
        i_cfg_we <= 1'b0;
    endtask

    // ---------------- output side ----------------
    int rx_wait = 0;
    int hold_cnt = 0;
    bit hold_done = 0;

    always @(posedge i_clk) begin
        t_pixel_result exp_res;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_m_tdata[31:0] !== exp_res.red) begin
                        $display("%0t: red_sum expected %h actual %h", $time,
                                 exp_res.red, o_m_tdata[31:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[63:32] !== exp_res.green) begin
                        $display("%0t: green_sum expected %h actual %h", $time,
                                 exp_res.green, o_m_tdata[63:32]);
                        fail_count++;
                    end
                    if (o_m_tdata[95:64] !== exp_res.blue) begin
                        $display("%0t: blue_sum expected %h actual %h", $time,
                                 exp_res.blue, o_m_tdata[95:64]);
                        fail_count++;
                    end
                    if (o_m_tdata[114:96] !== exp_res.orbit_x) begin
                        $display("%0t: orbit_x expected %h actual %h", $time,
                                 exp_res.orbit_x, o_m_tdata[114:96]);
                        fail_count++;
                    end
                    if (o_m_tdata[133:115] !== exp_res.orbit_y) begin
                        $display("%0t: orbit_y expected %h actual %h", $time,
                                 exp_res.orbit_y, o_m_tdata[133:115]);
                        fail_count++;
                    end
                    if (o_m_tuser[0] !== exp_res.plotted) begin
                        $display("%0t: plotted expected %b actual %b", $time,
                                 exp_res.plotted, o_m_tuser[0]);
                        fail_count++;
                    end
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 19);
            end
            // long hold-off to back the block up
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt  = 600;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any transaction (covers the reset clear pass)
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        send_item(cadp_pkg::OP_READ, 20'd0);
        send_item(cadp_pkg::OP_READ, 20'(cadp_pkg::NPIX - 1));
        send_item(cadp_pkg::OP_READ, 20'(cadp_pkg::NPIX));
        send_item(cadp_pkg::OP_READ, 20'hFFFFF);
        send_item(cadp_pkg::OP_NOP, 20'hAAAAA);
        // zero coefficients: orbit sits at the origin, skip rule holds 10 steps
        repeat (12) send_item(cadp_pkg::OP_STEP, 20'h55555);
        send_item(cadp_pkg::OP_READ, 20'(384 * 1024 + 512));
        send_item(cadp_pkg::OP_RESTART, 20'd0);
    endtask

    task automatic test_extremes();
        set_config(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 8'd0);
        send_item(cadp_pkg::OP_RESTART, 20'd0);
        repeat (4) send_item(cadp_pkg::OP_STEP, 20'd0);
        send_item(cadp_pkg::OP_READ, 20'(lit_pixels[$]));
        set_config(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 8'd255);
        send_item(cadp_pkg::OP_RESTART, 20'd0);
        repeat (3) send_item(cadp_pkg::OP_STEP, 20'd0);
        // lowered skip count takes effect at once
        set_config(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 8'd2);
        repeat (3) send_item(cadp_pkg::OP_STEP, 20'd0);
        send_item(cadp_pkg::OP_NOP, 20'd0);
    endtask

    task automatic test_random_orbits();
        logic [15:0] hue_pick[8] = '{16'h0000, 16'h2AAA, 16'h2AAB, 16'h5555,
                                     16'h8000, 16'hAAAB, 16'hD555, 16'hFFFF};
        logic [15:0] hue;
        int sel;
        for (int ph = 0; ph < 16; ph++) begin
            hue = ($urandom_range(0, 1) == 0) ? hue_pick[$urandom_range(0, 7)]
                                               : 16'($urandom);
            set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       hue, 8'($urandom_range(0, 12)));
            no_idle = (ph % 4 == 3);
            if (ph == 5) hold_req = 1;
            send_item(cadp_pkg::OP_RESTART, 20'($urandom));
            for (int k = 0; k < 100; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 78) begin
                    send_item(cadp_pkg::OP_STEP, 20'($urandom));
                end else if (sel < 90 && lit_pixels.size() != 0) begin
                    send_item(cadp_pkg::OP_READ, 20'(lit_pixels[$urandom_range(0,
                                                      lit_pixels.size() - 1)]));
                end else if (sel < 95) begin
                    send_item(cadp_pkg::OP_READ, 20'($urandom));
                end else if (sel < 98) begin
                    send_item(cadp_pkg::OP_NOP, 20'($urandom));
                end else begin
                    send_item(cadp_pkg::OP_RESTART, 20'($urandom));
                end
            end
            no_idle = 0;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = cadp_pkg::OP_NOP;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = cadp_pkg::CFG_COEF_A;
        i_cfg_wdata = '0;
        mdl_a = 0; mdl_b = 0; mdl_c = 0; mdl_d = 0;
        mdl_hue = 0; mdl_skip = 8'd10;
        mdl_x = 0; mdl_y = 0; mdl_skipped = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_extremes();
        test_random_orbits();

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
